>>> sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg - shared types and constants for the midpoint ellipse rasteriser
// Field widths, the command code and the command record that travels from
// the front end through the request queue to the back end.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int CW  = 11;   // centre coordinate width
    localparam int RW  = 10;   // semi-axis width
    localparam int PW  = 13;   // pixel coordinate width, two's complement
    localparam int XW  = 11;   // walk point coordinate width

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [CW-1:0]   cx;
        logic [CW-1:0]   cy;
        logic [RW-1:0]   rx;
        logic [RW-1:0]   ry;
    } t_cmd;

endpackage

>>> sv/mer_front.sv
// ----------------------------------------------------------------------------
// mer_front - request front end
// Classifies each incoming request as start or step and clamps the latched
// operands to the configured maxima before it is queued.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int RADIUS_MAX = 1023,
    parameter int COORD_MAX  = 2047
) (
    input  logic                     i_in_valid,
    input  logic                     i_op,
    input  logic [mer_pkg::CW-1:0]   i_ctr_x,
    input  logic [mer_pkg::CW-1:0]   i_ctr_y,
    input  logic [mer_pkg::RW-1:0]   i_axis_x,
    input  logic [mer_pkg::RW-1:0]   i_axis_y,
    input  logic                     i_q_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output mer_pkg::t_cmd            o_cmd
);
    import mer_pkg::*;

    localparam logic [16:0] RMAX = 17'(RADIUS_MAX);
    localparam logic [16:0] CMAX = 17'(COORD_MAX);

    logic [16:0] w_cx, w_cy, w_rx, w_ry;

    assign w_cx = 17'(i_ctr_x);
    assign w_cy = 17'(i_ctr_y);
    assign w_rx = 17'(i_axis_x);
    assign w_ry = 17'(i_axis_y);

    // a clamp only bites when the limit is below the field range, so it fits
    always_comb begin
        o_cmd.kind = (i_op == OP_START) ? CMD_START : CMD_STEP;
        o_cmd.cx   = (w_cx > CMAX) ? CMAX[CW-1:0] : i_ctr_x;
        o_cmd.cy   = (w_cy > CMAX) ? CMAX[CW-1:0] : i_ctr_y;
        o_cmd.rx   = (w_rx > RMAX) ? RMAX[RW-1:0] : i_axis_x;
        o_cmd.ry   = (w_ry > RMAX) ? RMAX[RW-1:0] : i_axis_y;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

>>> sv/mer_queue.sv
// ----------------------------------------------------------------------------
// mer_queue - two-entry request queue
// Decouples the front end from the back end so each side can stall alone.
// ----------------------------------------------------------------------------
module mer_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mer_pkg::t_cmd    i_cmd,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output mer_pkg::t_cmd    o_cmd
);
    import mer_pkg::*;

    t_cmd            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr, n_wr;
    logic [QAW-1:0]  r_rd, n_rd;
    logic [QCW-1:0]  r_count, n_count;
    logic            w_pop;

    assign w_pop   = i_pop & (r_count != '0);
    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count + QCW'(i_push) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QCW'(QDEPTH)) |-> !i_push)
        else $error("request queue written while full");

endmodule

>>> sv/mer_back.sv
// ----------------------------------------------------------------------------
// mer_back - rasteriser back end
// Sequencer around one shared multiplier: sets up a new ellipse, runs the
// region one / region two midpoint steps, evaluates the region two entry
// decision, then emits the four symmetric points through an output register.
// ----------------------------------------------------------------------------
module mer_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  mer_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [mer_pkg::PW-1:0] o_pixel_x,
    output logic signed [mer_pkg::PW-1:0] o_pixel_y,
    output logic                      o_quad_last,
    output logic                      o_curve_done
);
    import mer_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_RX2  = 16'h0002,
        ST_RY2  = 16'h0004,
        ST_SLY  = 16'h0008,
        ST_INIT = 16'h0010,
        ST_R1A  = 16'h0020,
        ST_R1B  = 16'h0040,
        ST_R2A  = 16'h0080,
        ST_R2B  = 16'h0100,
        ST_E1   = 16'h0200,
        ST_E2   = 16'h0400,
        ST_E3   = 16'h0800,
        ST_E4   = 16'h1000,
        ST_E5   = 16'h2000,
        ST_E6   = 16'h4000,
        ST_EMIT = 16'h8000
    } t_state;

    t_state          r_state, n_state;
    logic            r_in_r2, n_in_r2;
    logic            r_active, n_active;
    logic [1:0]      r_k, n_k;
    logic            r_out_valid, n_out_valid;

    logic [CW-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic [RW-1:0]   r_rx, n_rx, r_ry, n_ry;
    logic [19:0]     r_rx2, n_rx2, r_ry2, n_ry2;
    logic [XW-1:0]   r_x, n_x, r_y, n_y;
    logic [32:0]     r_sx, n_sx, r_sy, n_sy;
    logic [43:0]     r_dec, n_dec;
    logic            r_branch, n_branch;
    logic [23:0]     r_t1, n_t1;
    logic [21:0]     r_t2, n_t2;
    logic [45:0]     r_acc, n_acc;
    logic [43:0]     r_prod;
    logic [PW-1:0]   r_px, n_px, r_py, n_py;
    logic            r_ql, n_ql, r_cd, n_cd;

    logic [19:0]     w_mul_a;
    logic [23:0]     w_mul_b;
    logic [43:0]     w_prod;
    logic [45:0]     w_sx, w_sy, w_rx2, w_ry2, w_dec, w_prod4;
    logic [45:0]     w_r1_flat, w_r1_diag, w_r2_vert, w_r2_diag;
    logic [45:0]     w_init, w_e5, w_e6;
    logic [32:0]     w_2rx2, w_2ry2;
    logic [XW-1:0]   w_ty;
    logic [11:0]     w_tx;
    logic            w_load;
    logic [PW-1:0]   w_px, w_py;

    // ---- shared multiplier, product registered ----
    assign w_tx = {r_x, 1'b1};
    assign w_ty = (r_y == '0) ? XW'(1) : r_y - 1'b1;   // |y - 1|

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_RX2: begin
                w_mul_a = 20'(r_rx);
                w_mul_b = 24'(r_rx);
            end
            ST_RY2: begin
                w_mul_a = 20'(r_ry);
                w_mul_b = 24'(r_ry);
            end
            ST_SLY: begin
                w_mul_a = r_rx2;
                w_mul_b = 24'(r_ry);
            end
            ST_E1: begin
                w_mul_a = 20'(w_tx);
                w_mul_b = 24'(w_tx);
            end
            ST_E2: begin
                w_mul_a = 20'(w_ty);
                w_mul_b = 24'(w_ty);
            end
            ST_E3: begin
                w_mul_a = r_ry2;
                w_mul_b = r_t1;
            end
            ST_E4: begin
                w_mul_a = r_rx2;
                w_mul_b = 24'(r_t2);
            end
            ST_E5: begin
                w_mul_a = r_rx2;
                w_mul_b = 24'(r_ry2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = 44'(w_mul_a) * 44'(w_mul_b);

    // ---- decision arithmetic, modulo 2^46 then cut to 44 bits ----
    assign w_sx    = 46'(r_sx);
    assign w_sy    = 46'(r_sy);
    assign w_rx2   = 46'(r_rx2);
    assign w_ry2   = 46'(r_ry2);
    assign w_dec   = {{2{r_dec[43]}}, r_dec};
    assign w_prod4 = {r_prod, 2'b00};
    assign w_2rx2  = {12'd0, r_rx2, 1'b0};
    assign w_2ry2  = {12'd0, r_ry2, 1'b0};

    assign w_r1_flat = w_dec + ((w_sx + w_ry2) << 2);
    assign w_r1_diag = w_dec + ((w_sx - w_sy + w_ry2) << 2);
    assign w_r2_vert = w_dec + ((w_rx2 - w_sy) << 2);
    assign w_r2_diag = w_dec + ((w_sx - w_sy + w_rx2) << 2);
    assign w_init    = (w_ry2 << 2) - w_prod4 + w_rx2;
    assign w_e5      = r_acc + w_prod4;
    assign w_e6      = r_acc - w_prod4;

    // ---- point of the group: +x,+y / -x,+y / +x,-y / -x,-y ----
    assign w_px = r_k[0] ? PW'(r_cx) - PW'(r_x) : PW'(r_cx) + PW'(r_x);
    assign w_py = r_k[1] ? PW'(r_cy) - PW'(r_y) : PW'(r_cy) + PW'(r_y);

    assign w_load = ~r_out_valid | ~i_out_stall;

    assign o_pop = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_in_r2     = r_in_r2;
        n_active    = r_active;
        n_k         = r_k;
        n_out_valid = r_out_valid & i_out_stall;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_rx2       = r_rx2;
        n_ry2       = r_ry2;
        n_x         = r_x;
        n_y         = r_y;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dec       = r_dec;
        n_branch    = r_branch;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_acc       = r_acc;
        n_px        = r_px;
        n_py        = r_py;
        n_ql        = r_ql;
        n_cd        = r_cd;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.kind == CMD_START) begin
                        n_cx     = i_cmd.cx;
                        n_cy     = i_cmd.cy;
                        n_rx     = i_cmd.rx;
                        n_ry     = i_cmd.ry;
                        n_x      = '0;
                        n_y      = XW'(i_cmd.ry);
                        n_sx     = '0;
                        n_in_r2  = 1'b0;
                        n_active = 1'b1;
                        n_state  = ST_RX2;
                    end else if (r_active) begin
                        if (!r_in_r2) begin
                            n_state = ST_R1A;
                        end else if (r_y == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_state = ST_R2A;
                        end
                    end
                end
            end
            ST_RX2: begin
                n_state = ST_RY2;
            end
            ST_RY2: begin
                n_rx2   = r_prod[19:0];
                n_state = ST_SLY;
            end
            ST_SLY: begin
                n_ry2   = r_prod[19:0];
                n_state = ST_INIT;
            end
            ST_INIT: begin
                n_sy  = {r_prod[31:0], 1'b0};
                n_dec = w_init[43:0];
                n_k   = '0;
                if (r_prod[31:0] == '0) begin
                    n_state = ST_E1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_R1A: begin
                n_x      = r_x + 1'b1;
                n_sx     = r_sx + w_2ry2;
                n_branch = r_dec[43];
                if (!r_dec[43]) begin
                    n_y  = r_y - 1'b1;
                    n_sy = r_sy - w_2rx2;
                end
                n_state  = ST_R1B;
            end
            ST_R1B: begin
                n_dec = r_branch ? w_r1_flat[43:0] : w_r1_diag[43:0];
                n_k   = '0;
                if (r_sx < r_sy) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_E1;
                end
            end
            ST_R2A: begin
                n_y      = r_y - 1'b1;
                n_sy     = r_sy - w_2rx2;
                n_branch = ~r_dec[43] & (r_dec != '0);
                if (r_dec[43] || r_dec == '0) begin
                    n_x  = r_x + 1'b1;
                    n_sx = r_sx + w_2ry2;
                end
                n_state  = ST_R2B;
            end
            ST_R2B: begin
                n_dec   = r_branch ? w_r2_vert[43:0] : w_r2_diag[43:0];
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_E1: begin
                n_state = ST_E2;
            end
            ST_E2: begin
                n_t1    = r_prod[23:0];
                n_state = ST_E3;
            end
            ST_E3: begin
                n_t2    = r_prod[21:0];
                n_state = ST_E4;
            end
            ST_E4: begin
                n_acc   = {2'b00, r_prod};
                n_state = ST_E5;
            end
            ST_E5: begin
                n_acc   = w_e5;
                n_state = ST_E6;
            end
            ST_E6: begin
                n_dec   = w_e6[43:0];
                n_in_r2 = 1'b1;
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_px        = w_px;
                    n_py        = w_py;
                    n_ql        = (r_k == 2'd3);
                    n_cd        = (r_y == '0);
                    n_k         = r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        n_state = ST_IDLE;
                        if (r_y == '0) begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_r2     <= 1'b0;
            r_active    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_r2     <= n_in_r2;
            r_active    <= n_active;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_rx2    <= n_rx2;
        r_ry2    <= n_ry2;
        r_x      <= n_x;
        r_y      <= n_y;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_dec    <= n_dec;
        r_branch <= n_branch;
        r_t1     <= n_t1;
        r_t2     <= n_t2;
        r_acc    <= n_acc;
        r_prod   <= w_prod;
        r_px     <= n_px;
        r_py     <= n_py;
        r_ql     <= n_ql;
        r_cd     <= n_cd;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_quad_last  = r_ql;
    assign o_curve_done = r_cd;

    a_r2_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_r2) |-> $past(r_state) == ST_E6)
        else $error("region two entered without its decision set-up");

    // the final point may still sit in the output register after a new start
    a_last_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_load && r_k == 2'd3 && r_y == '0) |=> !r_active)
        else $error("curve still active after its final group");

    a_walk_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_y <= XW'(r_ry)))
        else $error("walk point y above the vertical semi-axis");

    a_r1_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_in_r2 && r_active) |-> (r_sx < r_sy))
        else $error("region one group emitted past the slope crossover");

endmodule

>>> sv/midpoint_ellipse_raster_top.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster_top - midpoint ellipse rasteriser
// Input channel takes start / step requests; output channel gives points.
//
// Input: i_in_valid / o_in_stall with i_op (0 start, 1 step) and the centre
// and semi-axes, read on start only. A request is taken on an edge with
// valid high and stall low; a two-entry queue lets requests in while the
// back end is busy. Output: o_out_valid / i_out_stall, one group of four
// points per request (+x+y, -x+y, +x-y, -x-y), o_quad_last on the
// fourth and o_curve_done on the whole group with y = 0.
// Steps per request, run by the sequencer and its single shared multiplier:
// dispatch from idle, then the start set-up states (RX2, RY2, SLY, INIT) or
// the step states (R1A, R1B or R2A, R2B), plus E1 to E6 when region two
// is entered, then EMIT pushes the group through the output register.
// A step after the final group gives no points.
// A stalled output holds its point and the sequencer waits; the queue then
// fills and o_in_stall rises. Reset empties the queue, drops the output
// and leaves the block idle with no curve active.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster_top #(
    parameter int RADIUS_MAX = 1023,
    parameter int COORD_MAX  = 2047
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [mer_pkg::CW-1:0]            i_ctr_x,
    input  logic [mer_pkg::CW-1:0]            i_ctr_y,
    input  logic [mer_pkg::RW-1:0]            i_axis_x,
    input  logic [mer_pkg::RW-1:0]            i_axis_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [mer_pkg::PW-1:0]     o_pixel_x,
    output logic signed [mer_pkg::PW-1:0]     o_pixel_y,
    output logic                              o_quad_last,
    output logic                              o_curve_done
);
    import mer_pkg::*;

    t_cmd    w_front_cmd;
    t_cmd    w_q_cmd;
    logic    w_push;
    logic    w_full;
    logic    w_q_valid;
    logic    w_pop;

    mer_front #(
        .RADIUS_MAX (RADIUS_MAX),
        .COORD_MAX  (COORD_MAX)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_ctr_x    (i_ctr_x),
        .i_ctr_y    (i_ctr_y),
        .i_axis_x   (i_axis_x),
        .i_axis_y   (i_axis_y),
        .i_q_full   (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    mer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    mer_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_quad_last  (o_quad_last),
        .o_curve_done (o_curve_done)
    );

endmodule
